[design/wsdf_pkg.sv]
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by websocket_frame_deframer.
`default_nettype none

package wsdf_pkg;

  // Default width of the payload length counter
  localparam int unsigned LENGTH_BITS_DEF = 64;

  // 7-bit length codes that announce an extended length
  localparam logic [6:0] CODE_LEN16 = 7'd126;
  localparam logic [6:0] CODE_LEN64 = 7'd127;

  // Extended length byte counts
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4,
    PH_DEAD = 3'd5
  } phase_t;

endpackage

`default_nettype wire

[design/websocket_frame_deframer.sv]
// A result is registered and appears on the out_ ports in the cycle after the byte that causes it.
// Throughput: one byte per cycle; the single result register sets the rate, and a
// new byte is taken whenever that register is empty or is being taken in the same cycle.
// Reset (rst_n low, synchronous): parser waits for a first header byte, no result pending.
// After an unmasked frame the parser drops all bytes until reset.
// Depends on wsdf_pkg.
`default_nettype none

module websocket_frame_deframer
  import wsdf_pkg::*;
#(
  parameter int unsigned LEN_BITS = LENGTH_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_data_byte,
  output logic [1:0]      out_kind,
  output logic            out_frame_last,
  output logic            out_msg_final,
  output logic [3:0]      out_frame_opcode
);

  localparam logic [LEN_BITS-1:0] LEN_ONE  = {{(LEN_BITS-1){1'b0}}, 1'b1};
  localparam logic [LEN_BITS-1:0] LEN_ZERO = '0;

  phase_t              phase_r, phase_nxt;
  logic                fin_r, fin_nxt;
  logic [3:0]          opcode_r, opcode_nxt;
  logic [3:0]          ext_left_r, ext_left_nxt;
  logic [LEN_BITS-1:0] rem_r, rem_nxt;
  logic [31:0]         key_r, key_nxt;
  logic [1:0]          key_idx_r, key_idx_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_data_r, out_data_nxt;
  kind_t               out_kind_r, out_kind_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_fin_r, out_fin_nxt;
  logic [3:0]          out_opcode_r, out_opcode_nxt;

  logic                in_acc;
  logic                emit;
  logic [6:0]          len7;
  logic [7:0]          key_byte;
  logic [LEN_BITS-1:0] rem_dec;
  logic [1:0]          key_idx_inc;

  assign in_stall    = out_valid_r && out_stall;
  assign in_acc      = in_valid && !in_stall;
  assign len7        = in_rx_byte[6:0];
  assign rem_dec     = rem_r - LEN_ONE;
  assign key_idx_inc = key_idx_r + 2'd1;
  // pick key byte (3 - index), first key byte in the top 8 bits
  assign key_byte    = 8'(key_r >> {~key_idx_r, 3'b000});

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_HDR0: phase_nxt = PH_HDR1;
      PH_HDR1: begin
        if (!in_rx_byte[7]) begin
          phase_nxt = PH_DEAD;
        end else if (len7 == CODE_LEN16 || len7 == CODE_LEN64) begin
          phase_nxt = PH_EXT;
        end else begin
          phase_nxt = PH_KEY;
        end
      end
      PH_EXT: begin
        if (ext_left_r == 4'd1) phase_nxt = PH_KEY;
      end
      PH_KEY: begin
        if (key_idx_inc == 2'd0) begin
          phase_nxt = (rem_r == LEN_ZERO) ? PH_HDR0 : PH_DATA;
        end
      end
      PH_DATA: begin
        if (rem_r == LEN_ONE) phase_nxt = PH_HDR0;
      end
      PH_DEAD: phase_nxt = PH_DEAD;
      default: phase_nxt = PH_HDR0;
    endcase
  end

  // Datapath and result
  always_comb begin
    fin_nxt        = fin_r;
    opcode_nxt     = opcode_r;
    ext_left_nxt   = ext_left_r;
    rem_nxt        = rem_r;
    key_nxt        = key_r;
    key_idx_nxt    = key_idx_r;
    emit           = 1'b0;
    out_data_nxt   = 8'd0;
    out_kind_nxt   = KIND_PAYLOAD;
    out_last_nxt   = 1'b0;
    out_fin_nxt    = fin_r;
    out_opcode_nxt = opcode_r;
    case (phase_r)
      PH_HDR0: begin
        fin_nxt    = in_rx_byte[7];
        opcode_nxt = in_rx_byte[3:0];
      end
      PH_HDR1: begin
        if (!in_rx_byte[7]) begin
          emit         = 1'b1;
          out_kind_nxt = KIND_ERROR;
          out_last_nxt = 1'b1;
        end else begin
          key_nxt     = '0;
          key_idx_nxt = 2'd0;
          if (len7 == CODE_LEN16) begin
            ext_left_nxt = EXT16_BYTES;
            rem_nxt      = LEN_ZERO;
          end else if (len7 == CODE_LEN64) begin
            ext_left_nxt = EXT64_BYTES;
            rem_nxt      = LEN_ZERO;
          end else begin
            ext_left_nxt = 4'd0;
            rem_nxt      = {{(LEN_BITS-7){1'b0}}, len7};
          end
        end
      end
      PH_EXT: begin
        // shift in big-endian, keep low LEN_BITS
        rem_nxt      = {rem_r[LEN_BITS-9:0], in_rx_byte};
        ext_left_nxt = ext_left_r - 4'd1;
      end
      PH_KEY: begin
        key_nxt     = {key_r[23:0], in_rx_byte};
        key_idx_nxt = key_idx_inc;
        if (key_idx_inc == 2'd0 && rem_r == LEN_ZERO) begin
          emit         = 1'b1;
          out_kind_nxt = KIND_EMPTY;
          out_last_nxt = 1'b1;
        end
      end
      PH_DATA: begin
        key_idx_nxt  = key_idx_inc;
        rem_nxt      = rem_dec;
        emit         = 1'b1;
        out_data_nxt = in_rx_byte ^ key_byte;
        out_last_nxt = (rem_r == LEN_ONE);
      end
      PH_DEAD: begin
        // drop everything until reset
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc && emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR0;
      fin_r       <= 1'b0;
      opcode_r    <= 4'd0;
      ext_left_r  <= 4'd0;
      rem_r       <= LEN_ZERO;
      key_r       <= 32'd0;
      key_idx_r   <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        phase_r    <= phase_nxt;
        fin_r      <= fin_nxt;
        opcode_r   <= opcode_nxt;
        ext_left_r <= ext_left_nxt;
        rem_r      <= rem_nxt;
        key_r      <= key_nxt;
        key_idx_r  <= key_idx_nxt;
      end
    end
  end

  // Result payload, loaded only with a new word
  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_data_r   <= out_data_nxt;
      out_kind_r   <= out_kind_nxt;
      out_last_r   <= out_last_nxt;
      out_fin_r    <= out_fin_nxt;
      out_opcode_r <= out_opcode_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data_byte    = out_data_r;
  assign out_kind         = out_kind_r;
  assign out_frame_last   = out_last_r;
  assign out_msg_final    = out_fin_r;
  assign out_frame_opcode = out_opcode_r;

  a_dead_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DEAD |=> phase_r == PH_DEAD)
    else $error("parser left the dead state without reset");

  a_ext_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_EXT |-> ext_left_r != 4'd0)
    else $error("extended length phase with no bytes left");

  a_data_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && phase_r == PH_DATA |=> out_valid && out_kind == KIND_PAYLOAD)
    else $error("payload byte produced no word");

  a_unmasked_err: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && phase_r == PH_HDR1 && !in_rx_byte[7]
    |=> out_valid && out_kind == KIND_ERROR && phase_r == PH_DEAD)
    else $error("unmasked frame not flagged");

  a_nonpayload_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_PAYLOAD |-> out_data_byte == 8'd0 && out_frame_last)
    else $error("empty or error word malformed");

endmodule

`default_nettype wire
